[rtl/mexp_pkg.sv]
// Package with the shared widths and types of the modular exponentiation block.
`default_nettype none

package mexp_pkg;

    // Width of the modulus, the operands and the result.
    localparam int WIDTH = 31;

    // Width of the bit counter of the modular multiply unit (holds WIDTH itself).
    localparam int CNT_W = $clog2(WIDTH + 1);

    typedef logic [WIDTH-1:0] t_word;

    // Status of the modular multiply unit as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_stat;

endpackage

`default_nettype wire

[rtl/mexp_if.sv]
// Request channels of the modular exponentiation block: operands in, power out.
`default_nettype none

interface mexp_in_if;
    import mexp_pkg::*;

    logic  valid;
    logic  ready;
    t_word base;
    t_word exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if;
    import mexp_pkg::*;

    logic  valid;
    logic  ready;
    t_word power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);
endinterface

`default_nettype wire

[rtl/mexp_mulmod.sv]
// Bit-serial modular multiplier: one bit of the multiplier per cycle, double and add.
`default_nettype none

module mexp_mulmod (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_start,
    input  wire mexp_pkg::t_word   i_a,
    input  wire mexp_pkg::t_word   i_b,
    input  wire mexp_pkg::t_word   i_m,
    output mexp_pkg::t_mm_stat     o_stat,
    output mexp_pkg::t_word        o_result
);
    import mexp_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_r;
    t_word            r_a;
    t_word            r_b;
    t_word            r_m;

    logic [WIDTH+1:0] w_add;
    logic [WIDTH+1:0] w_t;
    logic [WIDTH+1:0] w_m1;
    logic [WIDTH+1:0] w_m2;
    t_word            n_r;

    // One step: t = 2r + bit * a stays below 3m, so one subtraction of m or of 2m suffices.
    always_comb begin
        w_add = r_b[WIDTH-1] ? {2'b00, r_a} : '0;
        w_t   = {1'b0, r_r, 1'b0} + w_add;
        w_m1  = {2'b00, r_m};
        w_m2  = {1'b0, r_m, 1'b0};
        if (w_t >= w_m2) begin
            n_r = t_word'(w_t - w_m2);
        end else if (w_t >= w_m1) begin
            n_r = t_word'(w_t - w_m1);
        end else begin
            n_r = t_word'(w_t);
        end
    end

    // Control: load on start, scan the multiplier from its top bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_a <= i_a;
            r_b <= i_b;
            r_m <= i_m;
            r_r <= '0;
        end else if (r_busy) begin
            r_r <= n_r;
            r_b <= {r_b[WIDTH-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_r;

`ifndef SYNTH
    // The counter never sits at zero while a multiply runs.
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("mulmod busy with an empty bit counter");

    // Completion follows directly on the last step of a running multiply.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("mulmod done without a running multiply");
`endif

endmodule

`default_nettype wire

[rtl/mod_exponentiation.sv]
// Modular exponentiation: square-and-multiply sequencer around one bit-serial multiplier.
// An item needs one reduction of the base, one multiply per set exponent bit and one square per
// bit below the top set bit: at most 2 * WIDTH multiplies. A new request is accepted only once
// the result of the last one is registered. A modulus below two skips the multiplies and gives
// zero, and exponent zero gives one.
// Synchronous active-low reset sets the modulus to 2 and clears the output valid flag.
`default_nettype none

module mod_exponentiation (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_cfg_we,
    input  wire mexp_pkg::t_word   i_cfg_wdata,
    mexp_in_if.sink                i_in,
    mexp_out_if.source             o_out
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_MUL,
        S_SQR,
        S_DONE
    } t_state;

    t_state   r_state;
    t_word    r_modulus;
    t_word    r_exp;
    t_word    r_acc;
    t_word    r_base;
    logic     r_mm_start;
    logic     r_out_valid;
    t_word    r_power;

    t_word    w_mm_a;
    t_word    w_mm_b;
    t_word    w_mm_res;
    t_mm_stat w_mm_stat;

    // Operand selection for the shared multiply unit.
    always_comb begin
        unique case (r_state)
            S_REDUCE: begin
                w_mm_a = t_word'(1);
                w_mm_b = r_base;
            end
            S_MUL: begin
                w_mm_a = r_acc;
                w_mm_b = r_base;
            end
            default: begin
                w_mm_a = r_base;
                w_mm_b = r_base;
            end
        endcase
    end

    mexp_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mm_start),
        .i_a      (w_mm_a),
        .i_b      (w_mm_b),
        .i_m      (r_modulus),
        .o_stat   (w_mm_stat),
        .o_result (w_mm_res)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.power = r_power;

    // Sequencer: reduce the base (unless the modulus is below two), then walk the exponent from its low bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_modulus   <= t_word'(2);
            r_mm_start  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mm_start <= 1'b0;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_exp  <= i_in.exponent;
                        r_base <= i_in.base;
                        if (r_modulus < t_word'(2)) begin
                            r_acc   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_acc      <= t_word'(1);
                            r_mm_start <= 1'b1;
                            r_state    <= S_REDUCE;
                        end
                    end
                end
                S_REDUCE: begin
                    if (w_mm_stat.done) begin
                        r_base  <= w_mm_res;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_exp == '0) begin
                        r_state <= S_DONE;
                    end else if (r_exp[0]) begin
                        r_mm_start <= 1'b1;
                        r_state    <= S_MUL;
                    end else begin
                        r_mm_start <= 1'b1;
                        r_state    <= S_SQR;
                    end
                end
                S_MUL: begin
                    if (w_mm_stat.done) begin
                        r_acc <= w_mm_res;
                        if (r_exp[WIDTH-1:1] == '0) begin
                            // Last set bit: the final square is not needed.
                            r_exp   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_mm_start <= 1'b1;
                            r_state    <= S_SQR;
                        end
                    end
                end
                S_SQR: begin
                    if (w_mm_stat.done) begin
                        r_base  <= w_mm_res;
                        r_exp   <= {1'b0, r_exp[WIDTH-1:1]};
                        r_state <= S_STEP;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_power     <= r_acc;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // A multiply is only launched while the shared unit is free.
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mm_start |-> !w_mm_stat.busy)
        else $error("multiply launched while the unit is busy");

    // The block takes a new request only with the multiply unit idle.
    a_accept_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (!w_mm_stat.busy && !r_mm_start))
        else $error("request accepted with a multiply in flight");

    // A result appears only out of the finishing state.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result presented outside of the finishing state");

    // Completion of a multiply is only seen while the sequencer waits for one.
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mm_stat.done |-> (r_state == S_REDUCE || r_state == S_MUL || r_state == S_SQR))
        else $error("multiply finished while the sequencer was not waiting");
`endif

endmodule

`default_nettype wire
